### design/note_to_cv_glide_bend_assert.svh
`ifndef NOTE_TO_CV_GLIDE_BEND_ASSERT_SVH
`define NOTE_TO_CV_GLIDE_BEND_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NCV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NCV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ncv_pkg.sv
package ncv_pkg;

	localparam int unsigned GLIDE_LEN_DEF = 250;
	localparam int unsigned CODE_W = 16;

	typedef enum logic [2:0] {
		REG_TRANSPOSE,
		REG_BEND_ENABLE,
		REG_NOTE_MIN,
		REG_NOTE_MAX,
		REG_OOR_CODE,
		REG_DAC_MIN,
		REG_DAC_MAX
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  transpose;
		logic        bend_enable;
		logic [6:0]  note_min;
		logic [6:0]  note_max;
		logic [15:0] oor_code;
		logic [15:0] dac_min;
		logic [15:0] dac_max;
	} ncv_cfg_t;

	localparam ncv_cfg_t CFG_RESET = '{
		transpose:   8'd0,
		bend_enable: 1'b1,
		note_min:    7'd24,
		note_max:    7'd60,
		oor_code:    16'hFFFF,
		dac_min:     16'd0,
		dac_max:     16'd4095
	};

	// floor(d * 83.33333) for a note distance d above note_min
	typedef logic [13:0] code_lut_t [128];

	function automatic code_lut_t build_code_lut();
		code_lut_t t;
		for (int i = 0; i < 128; i++) begin
			t[i] = 14'((64'(i) * 64'd8333333) / 64'd100000);
		end
		return t;
	endfunction

	localparam code_lut_t CODE_LUT = build_code_lut();

endpackage

### design/ncv_item_if.sv
interface ncv_item_if;
	logic        valid;
	logic        ready;
	logic [31:0] tick_now;
	logic [31:0] note_start_ticks;
	logic [7:0]  cur_note;
	logic [7:0]  prev_note;
	logic        prev_valid;
	logic [13:0] bend_amount;

	modport source (
		output valid, tick_now, note_start_ticks, cur_note, prev_note, prev_valid,
			bend_amount,
		input  ready
	);
	modport sink (
		input  valid, tick_now, note_start_ticks, cur_note, prev_note, prev_valid,
			bend_amount,
		output ready
	);
endinterface

### design/ncv_result_if.sv
interface ncv_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] dac_value;

	modport source (output valid, dac_value, input ready);
	modport sink (input valid, dac_value, output ready);
endinterface

### design/ncv_cfg_if.sv
interface ncv_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/ncv_cfg_regs.sv
module ncv_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	ncv_cfg_if.sink          cfg,
	output ncv_pkg::ncv_cfg_t regs
);
	import ncv_pkg::*;

	ncv_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_TRANSPOSE:   regs_q.transpose   <= cfg.data[7:0];
				REG_BEND_ENABLE: regs_q.bend_enable <= cfg.data[0];
				REG_NOTE_MIN:    regs_q.note_min    <= cfg.data[6:0];
				REG_NOTE_MAX:    regs_q.note_max    <= cfg.data[6:0];
				REG_OOR_CODE:    regs_q.oor_code    <= cfg.data;
				REG_DAC_MIN:     regs_q.dac_min     <= cfg.data;
				REG_DAC_MAX:     regs_q.dac_max     <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule

### design/ncv_note_map.sv
module ncv_note_map (
	input  logic [7:0]        raw,
	input  ncv_pkg::ncv_cfg_t cfg,
	output logic [15:0]       code
);
	import ncv_pkg::*;

	logic [7:0] note;
	logic [6:0] span;
	logic       oor;

	always_comb begin
		note = raw + cfg.transpose;
		oor  = (note < {1'b0, cfg.note_min}) || (note > {1'b0, cfg.note_max});
		// in range implies note <= 127
		span = note[6:0] - cfg.note_min;
		code = oor ? cfg.oor_code : {2'b00, CODE_LUT[span]};
	end
endmodule

### design/ncv_recip_div.sv
module ncv_recip_div #(
	parameter int unsigned GLIDE_LEN = ncv_pkg::GLIDE_LEN_DEF
) (
	input  logic        clk,
	input  logic        ld_s4,
	input  logic        ld_s5,
	input  logic [31:0] num,
	output logic [15:0] quot
);
	import ncv_pkg::*;

	localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / 64'(GLIDE_LEN));
	localparam logic [31:0] DIVISOR = 32'(GLIDE_LEN);

	logic [64:0] prod;
	logic [31:0] num_s4;
	logic [15:0] qest_s4;
	logic [31:0] rem;
	logic [15:0] quot_s5;

	// estimate is the true quotient or one below it
	assign prod = {33'd0, num} * {32'd0, RECIP};

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			num_s4  <= num;
			qest_s4 <= prod[47:32];
		end
	end

	assign rem = num_s4 - (32'(qest_s4) * DIVISOR);

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			quot_s5 <= (rem >= DIVISOR) ? qest_s4 + 16'd1 : qest_s4;
		end
	end

	assign quot = quot_s5;
endmodule

### design/note_to_cv_glide_bend.sv
// Channel | Dir | Beat contents
// --------+-----+-------------------------------------------------------------
// notes   | in  | tick_now, note_start_ticks, cur_note, prev_note, prev_valid,
//         |     | bend_amount
// dac     | out | dac_value
// cfg     | in  | index, data (register write, always ready)
//
// One beat per cycle sustained while dac.ready holds; each result passes
// through six register stages: input, note codes, glide sum,
// reciprocal multiply, quotient correction, bend and clamp into the output register.
// Each stage takes a beat when empty or when the next stage moves, so bubbles close up
// and beats are still taken while a result waits on dac.ready, until every stage is full.
// Reset clears all stage valid bits and loads the register defaults.
`include "note_to_cv_glide_bend_assert.svh"

module note_to_cv_glide_bend #(
	parameter int unsigned GLIDE_LEN = ncv_pkg::GLIDE_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ncv_item_if.sink      notes,
	ncv_result_if.source  dac,
	ncv_cfg_if.sink       cfg
);
	import ncv_pkg::*;

	localparam logic [31:0] SLIDE32 = 32'(GLIDE_LEN);
	localparam logic [15:0] SLIDE16 = 16'(GLIDE_LEN);

	ncv_cfg_t cfg_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, res_valid_q;
	logic take_s1, take_s2, take_s3, take_s4, take_s5, take_out;

	logic [31:0] now_s1, start_s1;
	logic [7:0]  cur_s1, prev_s1;
	logic        pvalid_s1;
	logic [13:0] bend_s1, bend_s2, bend_s3, bend_s4, bend_s5;

	logic [31:0] elapsed;
	logic        glide;
	logic [15:0] cc_code, pc_code;

	logic [15:0] pc_s2, cc_s2, e_s2;
	logic [31:0] num;
	logic [31:0] num_s3;
	logic [15:0] quot;

	logic signed [11:0] offs;
	logic signed [17:0] sum;
	logic [15:0]        bend_code;
	logic [15:0]        res_data_q;

	logic clamp_on;
	logic in_window;

	ncv_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_q)
	);

	// per-stage ready chain
	assign take_out = !res_valid_q || dac.ready;
	assign take_s5  = !valid_s5 || take_out;
	assign take_s4  = !valid_s4 || take_s5;
	assign take_s3  = !valid_s3 || take_s4;
	assign take_s2  = !valid_s2 || take_s3;
	assign take_s1  = !valid_s1 || take_s2;
	assign notes.ready = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take_s1)  valid_s1    <= notes.valid;
			if (take_s2)  valid_s2    <= valid_s1;
			if (take_s3)  valid_s3    <= valid_s2;
			if (take_s4)  valid_s4    <= valid_s3;
			if (take_s5)  valid_s5    <= valid_s4;
			if (take_out) res_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			now_s1    <= notes.tick_now;
			start_s1  <= notes.note_start_ticks;
			cur_s1    <= notes.cur_note;
			prev_s1   <= notes.prev_note;
			pvalid_s1 <= notes.prev_valid;
			bend_s1   <= notes.bend_amount;
		end
	end

	ncv_note_map u_cur_map (
		.raw  (cur_s1),
		.cfg  (cfg_q),
		.code (cc_code)
	);

	ncv_note_map u_prev_map (
		.raw  (prev_s1),
		.cfg  (cfg_q),
		.code (pc_code)
	);

	assign elapsed = now_s1 - start_s1;
	assign glide   = pvalid_s1 && (elapsed < SLIDE32);

	// without glide, start from the current code with zero elapsed time
	always_ff @(posedge clk) begin
		if (take_s2) begin
			pc_s2   <= glide ? pc_code : cc_code;
			cc_s2   <= cc_code;
			e_s2    <= glide ? elapsed[15:0] : 16'd0;
			bend_s2 <= bend_s1;
		end
	end

	assign num = (32'(pc_s2) * 32'(SLIDE16 - e_s2)) + (32'(cc_s2) * 32'(e_s2));

	always_ff @(posedge clk) begin
		if (take_s3) begin
			num_s3  <= num;
			bend_s3 <= bend_s2;
		end
	end

	ncv_recip_div #(
		.GLIDE_LEN (GLIDE_LEN)
	) u_div (
		.clk   (clk),
		.ld_s4 (take_s4),
		.ld_s5 (take_s5),
		.num   (num_s3),
		.quot  (quot)
	);

	always_ff @(posedge clk) begin
		if (take_s4) bend_s4 <= bend_s3;
		if (take_s5) bend_s5 <= bend_s4;
	end

	always_comb begin
		offs = $signed({1'b0, bend_s5[13:3]}) - 12'sd1024;
		sum  = $signed({2'b00, quot}) + $signed({{6{offs[11]}}, offs});
		if (!cfg_q.bend_enable) begin
			bend_code = quot;
		end else if (sum < $signed({2'b00, cfg_q.dac_min})) begin
			bend_code = cfg_q.dac_min;
		end else if (sum > $signed({2'b00, cfg_q.dac_max})) begin
			bend_code = cfg_q.dac_max;
		end else begin
			bend_code = sum[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) res_data_q <= bend_code;
	end

	assign dac.valid     = res_valid_q;
	assign dac.dac_value = res_data_q;

	assign clamp_on  = valid_s5 && cfg_q.bend_enable && (cfg_q.dac_min <= cfg_q.dac_max);
	assign in_window = (bend_code >= cfg_q.dac_min) && (bend_code <= cfg_q.dac_max);

	`NCV_ASSERT_NOW(a_clamp_window, clamp_on, in_window, "bent code outside clamp window")
	`NCV_ASSERT_NOW(a_glide_span, valid_s2, e_s2 < SLIDE16, "glide elapsed time not below slide time")
	`NCV_ASSERT_NEXT(a_hold_s1, valid_s1 && !take_s2, valid_s1, "stage one lost a stalled item")
endmodule
